### rtl/tms_pkg.sv
// Shared types and codes for the trackball motion to scroll block.
package tms_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_THR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_THR = 1'd1;

    localparam logic [6:0] SCROLL_THR_RST = 7'd8;
    localparam logic [6:0] VOLUME_THR_RST = 7'd16;

    localparam logic [1:0] MODE_POINTER = 2'd0;
    localparam logic [1:0] MODE_SCROLL  = 2'd1;
    localparam logic [1:0] MODE_VOLUME  = 2'd2;

    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_WHEEL_DOWN  = 3'd1;
    localparam logic [2:0] ACT_WHEEL_UP    = 3'd2;
    localparam logic [2:0] ACT_VOLUME_DOWN = 3'd3;
    localparam logic [2:0] ACT_VOLUME_UP   = 3'd4;

    typedef struct packed {
        logic [7:0] motion_byte;
        logic [7:0] dx_low;
        logic [7:0] dx_high;
        logic [7:0] dy_low;
        logic [7:0] dy_high;
        logic [1:0] mode;
    } t_tms_req;

    typedef struct packed {
        logic              report_valid;
        logic signed [7:0] report_x;
        logic signed [7:0] report_y;
        logic [2:0]        action;
    } t_tms_res;

endpackage

### rtl/tms_req_if.sv
// Request channel carrying one sensor motion burst.
interface tms_req_if import tms_pkg::*; ();
    logic     valid;
    logic     ready;
    t_tms_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/tms_res_if.sv
// Result channel carrying one pointer report or scroll/volume action.
interface tms_res_if import tms_pkg::*; ();
    logic     valid;
    logic     ready;
    t_tms_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/trackball_motion_to_scroll_top.sv
// Trackball motion burst to pointer report or scroll/volume step converter.
//
// i_req takes one sensor burst per request (motion byte, X/Y delta bytes,
// mode); o_res gives exactly one result per request, in order. Both channels
// move a request at a clock edge with valid and ready high.
// The cfg port writes scroll_threshold (index 0) and volume_threshold
// (index 1); write only while no request is in flight.
// A request accepted on i_req passes the input register, then the result
// register, before it shows on o_res. One request per cycle while o_res
// does not stall; the saturate and step-counter update are combinational
// logic between the two registers.
// If o_res stalls, the result register holds; the input register still
// takes one more request, then i_req.ready drops until o_res drains.
// Synchronous active-low reset empties both stages, clears the step counter
// and loads thresholds 8 (scroll) and 16 (volume).
module trackball_motion_to_scroll_top import tms_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tms_req_if.sink               i_req,
    tms_res_if.source             o_res
);

    logic              r_s1_valid;
    t_tms_req          r_s1;
    logic              r_out_valid;
    t_tms_res          r_out;
    logic signed [7:0] r_cnt;
    logic [6:0]        r_scroll_thr;
    logic [6:0]        r_volume_thr;

    logic              s1_adv;
    t_tms_res          n_out;
    logic signed [7:0] n_cnt;
    logic signed [7:0] rx;
    logic signed [7:0] ry;
    logic signed [8:0] cnt_x;
    logic signed [8:0] thr_s;

    function automatic logic signed [7:0] clamp16(input logic [7:0] hi, input logic [7:0] lo);
        logic signed [15:0] v;
        v = signed'({hi, lo});
        if (v > 16'sd127) begin
            return 8'sd127;
        end else if (v < -16'sd127) begin
            return -8'sd127;
        end
        return v[7:0];
    endfunction

    assign s1_adv      = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_comb begin
        n_out = '0;
        n_cnt = r_cnt;
        rx    = clamp16(r_s1.dy_high, r_s1.dy_low);
        ry    = clamp16(r_s1.dx_high, r_s1.dx_low);
        cnt_x = 9'(r_cnt);
        thr_s = signed'({2'b00, (r_s1.mode == MODE_SCROLL) ? r_scroll_thr : r_volume_thr});
        if (r_s1.motion_byte[7]) begin
            if (r_s1.mode == MODE_SCROLL || r_s1.mode == MODE_VOLUME) begin
                if (ry < 8'sd0 && r_cnt != -8'sd128) begin
                    cnt_x = cnt_x - 9'sd1;
                end
                if (ry > 8'sd0 && r_cnt != 8'sd127) begin
                    cnt_x = cnt_x + 9'sd1;
                end
                priority if (cnt_x > thr_s) begin
                    n_out.action = (r_s1.mode == MODE_SCROLL) ? ACT_WHEEL_DOWN : ACT_VOLUME_DOWN;
                    cnt_x        = '0;
                end else if (cnt_x < -thr_s) begin
                    n_out.action = (r_s1.mode == MODE_SCROLL) ? ACT_WHEEL_UP : ACT_VOLUME_UP;
                    cnt_x        = '0;
                end else begin
                    n_out.action = ACT_NONE;
                end
                n_cnt = cnt_x[7:0];
            end else begin
                n_out.report_valid = 1'b1;
                n_out.report_x     = rx;
                n_out.report_y     = ry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
            r_scroll_thr <= SCROLL_THR_RST;
            r_volume_thr <= VOLUME_THR_RST;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_cnt <= n_cnt;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SCROLL_THR: r_scroll_thr <= i_cfg_data;
                    CFG_VOLUME_THR: r_volume_thr <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_s1 <= i_req.data;
        end
        if (s1_adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

endmodule

### rtl/tms_checker.sv
// Port-level assertions for the trackball motion to scroll block, with bind.
module tms_checker import tms_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_out_valid,
    input logic     i_out_ready,
    input t_tms_res i_out_data
);

    // a stalled result must stay offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_report_no_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.report_valid |-> i_out_data.action == ACT_NONE)
        else $error("pointer report carries an action");

    a_act_no_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.action != ACT_NONE |->
        !i_out_data.report_valid && i_out_data.report_x == 8'sd0 &&
        i_out_data.report_y == 8'sd0)
        else $error("action result carries report data");

    a_act_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.action <= ACT_VOLUME_UP)
        else $error("undefined action code");

endmodule

bind trackball_motion_to_scroll_top tms_checker u_tms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

### test/tb.sv
// Self-checking testbench for the trackball motion to scroll/volume converter.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tms_pkg::*;

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int PHASE_BURSTS   = 250;
    localparam int WATCHDOG_LIMIT = 2000;

    // Tracks thresholds and the shared step counter; predicts one result per request.
    class scroll_scoreboard;
        logic [6:0] scroll_thr;
        logic [6:0] volume_thr;
        int         step_cnt;
        t_tms_res   pending[$];
        int         n_fail;
        int         n_bursts;
        int         n_reports;
        int         n_wheel;
        int         n_volume;

        function new();
            scroll_thr = SCROLL_THR_RST;
            volume_thr = VOLUME_THR_RST;
            step_cnt   = 0;
            n_fail     = 0;
            n_bursts   = 0;
            n_reports  = 0;
            n_wheel    = 0;
            n_volume   = 0;
        endfunction

        function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [6:0] value);
            if (idx == CFG_SCROLL_THR) begin
                scroll_thr = value;
            end else if (idx == CFG_VOLUME_THR) begin
                volume_thr = value;
            end
        endfunction

        function logic signed [7:0] clamp_delta(logic [7:0] hi, logic [7:0] lo);
            logic signed [15:0] raw;
            raw = {hi, lo};
            if (raw > 16'sd127) return 8'sd127;
            if (raw < -16'sd127) return -8'sd127;
            return raw[7:0];
        endfunction

        function void note_burst(t_tms_req r);
            t_tms_res          e;
            logic signed [7:0] rx;
            logic signed [7:0] ry;
            int                thr;
            e = '0;
            n_bursts++;
            if (r.motion_byte[7]) begin
                // axes swapped: pointer X from sensor Y
                rx = clamp_delta(r.dy_high, r.dy_low);
                ry = clamp_delta(r.dx_high, r.dx_low);
                if (r.mode != MODE_SCROLL && r.mode != MODE_VOLUME) begin
                    e.report_valid = 1'b1;
                    e.report_x     = rx;
                    e.report_y     = ry;
                    n_reports++;
                end else begin
                    if (ry < 0 && step_cnt > -128) step_cnt--;
                    if (ry > 0 && step_cnt < 127) step_cnt++;
                    thr = (r.mode == MODE_SCROLL) ? int'(scroll_thr) : int'(volume_thr);
                    if (step_cnt > thr) begin
                        e.action = (r.mode == MODE_SCROLL) ? ACT_WHEEL_DOWN : ACT_VOLUME_DOWN;
                        step_cnt = 0;
                    end
                    if (step_cnt < -thr) begin
                        e.action = (r.mode == MODE_SCROLL) ? ACT_WHEEL_UP : ACT_VOLUME_UP;
                        step_cnt = 0;
                    end
                    if (e.action != ACT_NONE) begin
                        if (r.mode == MODE_SCROLL) n_wheel++;
                        else n_volume++;
                    end
                end
            end
            pending.push_back(e);
        endfunction

        function void flag_field(string field, int want, int got);
            n_fail++;
            if (n_fail <= 20)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        endfunction

        function void check_result(t_tms_res got);
            t_tms_res e;
            if (pending.size() == 0) begin
                n_fail++;
                if (n_fail <= 20)
                    $display("%0t: unexpected result: expected none, actual %p", $time, got);
                return;
            end
            e = pending.pop_front();
            if (got.report_valid !== e.report_valid)
                flag_field("report_valid", e.report_valid, got.report_valid);
            if (got.report_x !== e.report_x) flag_field("report_x", e.report_x, got.report_x);
            if (got.report_y !== e.report_y) flag_field("report_y", e.report_y, got.report_y);
            if (got.action !== e.action) flag_field("action", e.action, got.action);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  calm;
    int                    quiet_cycles;

    tms_req_if req_ch ();
    tms_res_if res_ch ();

    scroll_scoreboard sb = new();

    trackball_motion_to_scroll_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_tms_req make_req(logic [7:0] mb, logic [15:0] dx, logic [15:0] dy,
                                          logic [1:0] m);
        t_tms_req r;
        r.motion_byte = mb;
        r.dx_low      = dx[7:0];
        r.dx_high     = dx[15:8];
        r.dy_low      = dy[7:0];
        r.dy_high     = dy[15:8];
        r.mode        = m;
        return r;
    endfunction

    // dir > 0 forces a positive delta, dir < 0 a negative one
    function automatic logic [15:0] pick_delta(int dir);
        logic signed [15:0] v;
        int                 roll;
        int                 tmp;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            v = 16'($urandom);
        end else if (roll == 1) begin
            case ($urandom_range(0, 8))
                0: v = 16'h7FFF;
                1: v = 16'h8000;
                2: v = 16'h007F;
                3: v = 16'h0080;
                4: v = 16'hFF81;
                5: v = 16'hFF80;
                6: v = 16'h0000;
                7: v = 16'h0001;
                default: v = 16'hFFFF;
            endcase
        end else begin
            tmp = int'($urandom_range(0, 400)) - 200;
            v = 16'(tmp);
        end
        if (dir > 0 && v <= 0) v = 16'($urandom_range(1, 300));
        if (dir < 0 && v >= 0) begin
            tmp = -int'($urandom_range(1, 300));
            v = 16'(tmp);
        end
        return v;
    endfunction

    function automatic t_tms_req motion_burst(logic [1:0] m, int dir);
        return make_req({1'b1, 7'($urandom)}, pick_delta(dir), pick_delta(0), m);
    endfunction

    function automatic t_tms_req noise_burst();
        logic [7:0] mb;
        mb = 8'($urandom);
        if ($urandom_range(0, 3) != 0) mb[7] = 1'b0;
        return make_req(mb, 16'($urandom), 16'($urandom), 2'($urandom_range(0, 3)));
    endfunction

    task automatic send_burst(t_tms_req r);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            req_ch.valid = 1'b0;
            req_ch.data  = make_req(8'($urandom), 16'($urandom), 16'($urandom),
                                    2'($urandom));
        end
        @(negedge i_clk);
        req_ch.valid = 1'b1;
        req_ch.data  = r;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_burst(r);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [CFG_IDX_W-1:0] idx, logic [6:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.set_threshold(idx, value);
    endtask

    // Mixed groups: same-direction scroll/volume runs of up to threshold + 3 bursts, pointer runs, mixed modes, noise.
    task automatic run_phase(int n_items);
        int         done;
        int         len;
        int         k;
        int         dir;
        int         thr;
        int         kind;
        logic [1:0] m;
        done = 0;
        while (done < n_items) begin
            calm = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                m   = $urandom_range(0, 1) ? MODE_SCROLL : MODE_VOLUME;
                thr = (m == MODE_SCROLL) ? int'(sb.scroll_thr) : int'(sb.volume_thr);
                dir = $urandom_range(0, 1) ? 1 : -1;
                len = $urandom_range(1, thr + 3);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 99) < 85) send_burst(motion_burst(m, dir));
                    else send_burst(noise_burst());
                end
            end else if (kind < 70) begin
                len = $urandom_range(1, 10);
                for (k = 0; k < len; k++) begin
                    m = ($urandom_range(0, 9) == 0) ? MODE_RESERVED : MODE_POINTER;
                    send_burst(motion_burst(m, 0));
                end
            end else if (kind < 85) begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++)
                    send_burst(motion_burst(2'($urandom_range(0, 3)), 0));
            end else begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++) send_burst(noise_burst());
            end
            done += len;
        end
        calm = 1'b0;
    endtask

    // result sink with random back-pressure
    initial begin
        int stall_left = 0;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_ch.ready = 1'b0;
                stall_left--;
            end else begin
                res_ch.ready = 1'b1;
                stall_left = pick_gap();
            end
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            !i_rst_n || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        int p;
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset thresholds: no-motion, clamp edges, reserved mode, zero step
        send_burst(make_req(8'h7F, 16'hFFFF, 16'h8000, MODE_POINTER));
        send_burst(make_req(8'h00, 16'h0005, 16'h0001, MODE_SCROLL));
        send_burst(make_req(8'h80, 16'h7FFF, 16'h8000, MODE_POINTER));
        send_burst(make_req(8'hFF, 16'h0080, 16'hFF80, MODE_POINTER));
        send_burst(make_req(8'hC3, 16'h007F, 16'hFF81, MODE_POINTER));
        send_burst(make_req(8'h80, 16'h0000, 16'h0000, MODE_POINTER));
        send_burst(make_req(8'h81, 16'h0001, 16'hFFFF, MODE_RESERVED));
        send_burst(make_req(8'hAA, 16'h1234, 16'hEDCC, MODE_RESERVED));
        send_burst(make_req(8'h80, 16'h0000, 16'h7FFF, MODE_SCROLL));

        run_phase(PHASE_BURSTS);
        drain();

        // low thresholds: every action, counter kept across a mode change
        write_threshold(CFG_SCROLL_THR, 7'd1);
        write_threshold(CFG_VOLUME_THR, 7'd2);
        send_burst(make_req(8'h80, 16'h0005, 16'h0010, MODE_SCROLL));
        send_burst(make_req(8'h80, 16'h7FFF, 16'hFFF0, MODE_SCROLL));
        send_burst(make_req(8'h80, 16'hFFFF, 16'h0000, MODE_SCROLL));
        send_burst(make_req(8'h80, 16'h8000, 16'h7FFF, MODE_SCROLL));
        send_burst(make_req(8'h80, 16'h0001, 16'h0001, MODE_SCROLL));
        send_burst(make_req(8'h80, 16'h0001, 16'h0002, MODE_VOLUME));
        send_burst(make_req(8'h80, 16'h0001, 16'h0003, MODE_VOLUME));
        send_burst(make_req(8'h80, 16'hFFFF, 16'h0004, MODE_VOLUME));
        send_burst(make_req(8'h80, 16'hFFFF, 16'h0005, MODE_VOLUME));
        send_burst(make_req(8'h80, 16'hFFFF, 16'h0006, MODE_VOLUME));
        send_burst(make_req(8'h7F, 16'h0040, 16'h0007, MODE_SCROLL));

        for (p = 0; p < 4; p++) begin
            drain();
            case (p)
                0: begin
                    write_threshold(CFG_SCROLL_THR, 7'd1);
                    write_threshold(CFG_VOLUME_THR, 7'd126);
                end
                1: begin
                    write_threshold(CFG_SCROLL_THR, 7'd126);
                    write_threshold(CFG_VOLUME_THR, 7'd1);
                end
                default: begin
                    write_threshold(CFG_SCROLL_THR, 7'($urandom_range(1, 126)));
                    write_threshold(CFG_VOLUME_THR, 7'($urandom_range(1, 126)));
                end
            endcase
            run_phase(PHASE_BURSTS);
        end
        drain();
        repeat (6) @(posedge i_clk);

        $display("Sent %0d bursts: %0d pointer reports, %0d wheel and %0d volume steps,",
                 sb.n_bursts, sb.n_reports, sb.n_wheel, sb.n_volume);
        $display("thresholds swept 1..126 in six settings, mixed stalls on both channels.");
        if (sb.n_fail == 0 && sb.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
